### rtl/mmdps_pkg.sv
package mmdps_pkg;

  localparam int RAW_W          = 20;
  localparam int DIST_W         = 42;
  localparam int INDEX_W        = 6;
  localparam int MAX_REFERENCES = 64;
  localparam int MAX_CANDIDATES = 64;
  localparam int COORD_BITS     = 20;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam logic FUNC_REFERENCE = 1'b0;
  localparam logic FUNC_CANDIDATE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic init;
    logic valid;
  } dist_ctl_t;

endpackage

### rtl/mmdps_ref_store.sv
module mmdps_ref_store
  import mmdps_pkg::*;
#(
  parameter int DEPTH  = MAX_REFERENCES,
  parameter int DATA_W = 3 * COORD_BITS,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/mmdps_dist_unit.sv
module mmdps_dist_unit
  import mmdps_pkg::*;
#(
  parameter int COORD_BITS = mmdps_pkg::COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  dist_ctl_t                    ctl,
  input  logic signed [COORD_BITS-1:0] ref_x,
  input  logic signed [COORD_BITS-1:0] ref_y,
  input  logic signed [COORD_BITS-1:0] ref_z,
  input  logic signed [COORD_BITS-1:0] cand_x,
  input  logic signed [COORD_BITS-1:0] cand_y,
  input  logic signed [COORD_BITS-1:0] cand_z,
  output logic                         pending,
  output logic [DIST_W-1:0]            closest
);

  localparam int AB_W  = COORD_BITS + 1;
  localparam int SQ_W  = 2 * AB_W;
  localparam int SUM_W = SQ_W + 2;
  localparam int CMP_W = (SUM_W > DIST_W) ? SUM_W : DIST_W;

  logic signed [AB_W-1:0] dx, dy, dz;
  logic [AB_W-1:0]        ax, ay, az;
  logic [SQ_W-1:0]        sq_x, sq_y, sq_z;
  logic [SUM_W-1:0]       sum;
  logic [CMP_W-1:0]       sum_ext;
  logic [DIST_W-1:0]      d_sat;

  assign dx = {ref_x[COORD_BITS-1], ref_x} - {cand_x[COORD_BITS-1], cand_x};
  assign dy = {ref_y[COORD_BITS-1], ref_y} - {cand_y[COORD_BITS-1], cand_y};
  assign dz = {ref_z[COORD_BITS-1], ref_z} - {cand_z[COORD_BITS-1], cand_z};

  assign ax = dx[AB_W-1] ? AB_W'(-dx) : AB_W'(dx);
  assign ay = dy[AB_W-1] ? AB_W'(-dy) : AB_W'(dy);
  assign az = dz[AB_W-1] ? AB_W'(-dz) : AB_W'(dz);

  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      sq_x <= SQ_W'(ax) * SQ_W'(ax);
      sq_y <= SQ_W'(ay) * SQ_W'(ay);
      sq_z <= SQ_W'(az) * SQ_W'(az);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else begin
      pending <= ctl.valid;
    end
  end

  assign sum     = SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);
  assign sum_ext = CMP_W'(sum);
  assign d_sat   = (sum_ext > CMP_W'(DIST_MAX)) ? DIST_MAX : sum_ext[DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (rst || ctl.init) begin
      closest <= DIST_MAX;
    end else if (pending && (d_sat < closest)) begin
      closest <= d_sat;
    end
  end

endmodule

### rtl/max_min_distance_point_select.sv
// Max-min distance point selector. Send reference points (func = 0) first, then
// candidate points (func = 1); each transaction is taken when start is high and
// busy is low. A reference point never raises busy. A candidate holds busy from
// acceptance until it has been scored against all N stored references, since
// one registered distance unit visits the reference memory one entry per cycle
// and then drains its two-stage pipeline; with no references, or with the
// candidate limit reached, it skips the memory walk and goes to finish. The
// candidate marked last produces one result, with done high for exactly one
// cycle, the first cycle in which busy is low again; there is no way to stall
// it, so the receiver must sample it then. All state is cleared with that result.
module max_min_distance_point_select
  import mmdps_pkg::*;
#(
  parameter int MAX_REFERENCES = mmdps_pkg::MAX_REFERENCES,
  parameter int MAX_CANDIDATES = mmdps_pkg::MAX_CANDIDATES,
  parameter int COORD_BITS     = mmdps_pkg::COORD_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    func,
  input  logic signed [RAW_W-1:0] pos_x,
  input  logic signed [RAW_W-1:0] pos_y,
  input  logic signed [RAW_W-1:0] pos_z,
  input  logic                    excluded,
  input  logic                    last,
  output logic                    done,
  output logic                    found,
  output logic [INDEX_W-1:0]      best_index,
  output logic [DIST_W-1:0]       best_distance_sq,
  output logic                    no_references,
  output logic                    overflow
);

  localparam int AW     = (MAX_REFERENCES > 1) ? $clog2(MAX_REFERENCES) : 1;
  localparam int RCW    = $clog2(MAX_REFERENCES + 1);
  localparam int CCW    = $clog2(MAX_CANDIDATES + 1);
  localparam int DATA_W = 3 * COORD_BITS;
  localparam int EXT_W  = RAW_W + COORD_BITS;

  state_t state, state_next;

  logic [RCW-1:0]        ref_count;
  logic [CCW-1:0]        cand_count;
  logic [INDEX_W-1:0]    best_idx;
  logic [DIST_W-1:0]     best_dist;
  logic                  have_best;
  logic                  dropped;
  logic [RCW-1:0]        issue_cnt;
  logic                  rd_valid;
  logic                  c_last;
  logic                  c_scored;
  logic [COORD_BITS-1:0] c_x, c_y, c_z;

  logic [INDEX_W-1:0]    best_idx_next;
  logic [DIST_W-1:0]     best_dist_next;
  logic                  have_best_next;
  logic                  dropped_next;
  logic [DIST_W-1:0]     closest_eff;

  logic                  accept;
  logic                  ref_write;
  logic                  rd_en;
  logic [COORD_BITS-1:0] in_x, in_y, in_z;
  logic [EXT_W-1:0]      ext_x, ext_y, ext_z;
  logic [CCW+INDEX_W-1:0] cand_idx_ext;
  logic [DATA_W-1:0]     rdata;
  logic [DIST_W-1:0]     closest;
  logic                  pending;
  dist_ctl_t             dctl;

  assign accept = start && !busy;

  assign ext_x = {{COORD_BITS{1'b0}}, pos_x};
  assign ext_y = {{COORD_BITS{1'b0}}, pos_y};
  assign ext_z = {{COORD_BITS{1'b0}}, pos_z};
  assign in_x  = ext_x[COORD_BITS-1:0];
  assign in_y  = ext_y[COORD_BITS-1:0];
  assign in_z  = ext_z[COORD_BITS-1:0];

  assign ref_write = accept && (func == FUNC_REFERENCE) && !excluded &&
                     (ref_count < RCW'(MAX_REFERENCES));

  mmdps_ref_store #(
    .DEPTH  (MAX_REFERENCES),
    .DATA_W (DATA_W)
  ) u_store (
    .clk   (clk),
    .we    (ref_write),
    .waddr (ref_count[AW-1:0]),
    .wdata ({in_x, in_y, in_z}),
    .re    (rd_en),
    .raddr (issue_cnt[AW-1:0]),
    .rdata (rdata)
  );

  assign dctl.init  = accept && (func == FUNC_CANDIDATE);
  assign dctl.valid = rd_valid;

  mmdps_dist_unit #(
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk     (clk),
    .rst     (rst),
    .ctl     (dctl),
    .ref_x   (rdata[3*COORD_BITS-1:2*COORD_BITS]),
    .ref_y   (rdata[2*COORD_BITS-1:COORD_BITS]),
    .ref_z   (rdata[COORD_BITS-1:0]),
    .cand_x  (c_x),
    .cand_y  (c_y),
    .cand_z  (c_z),
    .pending (pending),
    .closest (closest)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (func == FUNC_CANDIDATE)) begin
          if ((cand_count < CCW'(MAX_CANDIDATES)) && (ref_count != '0)) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (issue_cnt == ref_count - RCW'(1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_valid && !pending) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy  = 1'b1;
    rd_en = 1'b0;
    unique case (state)
      ST_IDLE:   busy  = 1'b0;
      ST_SCAN:   rd_en = 1'b1;
      ST_DRAIN,
      ST_FINISH: busy  = 1'b1;
      default:   busy  = 1'b1;
    endcase
  end

  assign cand_idx_ext = {{INDEX_W{1'b0}}, cand_count};
  assign closest_eff  = (ref_count == '0) ? '0 : closest;

  always_comb begin
    best_idx_next  = best_idx;
    best_dist_next = best_dist;
    have_best_next = have_best;
    dropped_next   = dropped;
    if (c_scored) begin
      if (!have_best || (closest_eff > best_dist)) begin
        have_best_next = 1'b1;
        best_dist_next = closest_eff;
        best_idx_next  = cand_idx_ext[INDEX_W-1:0];
      end
    end else begin
      dropped_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ref_count <= '0;
      cand_count <= '0;
      best_idx  <= '0;
      best_dist <= '0;
      have_best <= 1'b0;
      dropped   <= 1'b0;
      issue_cnt <= '0;
      rd_valid  <= 1'b0;
      done      <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= rd_en;
      done     <= (state == ST_FINISH) && c_last;
      if (accept) begin
        if (func == FUNC_REFERENCE) begin
          if (ref_write) begin
            ref_count <= ref_count + RCW'(1);
          end else if (!excluded) begin
            dropped <= 1'b1;
          end
        end else begin
          issue_cnt <= '0;
        end
      end
      if (rd_en) begin
        issue_cnt <= issue_cnt + RCW'(1);
      end
      if (state == ST_FINISH) begin
        if (c_last) begin
          ref_count  <= '0;
          cand_count <= '0;
          best_idx   <= '0;
          best_dist  <= '0;
          have_best  <= 1'b0;
          dropped    <= 1'b0;
        end else begin
          best_idx  <= best_idx_next;
          best_dist <= best_dist_next;
          have_best <= have_best_next;
          dropped   <= dropped_next;
          if (c_scored) begin
            cand_count <= cand_count + CCW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (func == FUNC_CANDIDATE)) begin
      c_x      <= in_x;
      c_y      <= in_y;
      c_z      <= in_z;
      c_last   <= last;
      c_scored <= cand_count < CCW'(MAX_CANDIDATES);
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FINISH) && c_last) begin
      found            <= have_best_next;
      best_index       <= have_best_next ? best_idx_next : '0;
      best_distance_sq <= (have_best_next && (ref_count != '0)) ? best_dist_next : '0;
      no_references    <= ref_count == '0;
      overflow         <= dropped_next;
    end
  end

  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_FINISH))
    else $error("result strobe without a finished candidate");

  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    done |-> (ref_count == '0) && (cand_count == '0) && !have_best)
    else $error("state not cleared with the result");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (issue_cnt < ref_count))
    else $error("reference walk past the stored count");

  a_drain_complete: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> (issue_cnt == ref_count))
    else $error("drain entered before every reference was issued");

endmodule

### dv/mmdps_checker.sv
module mmdps_checker
  import mmdps_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               func,
  input  logic [RAW_W-1:0]   pos_x,
  input  logic [RAW_W-1:0]   pos_y,
  input  logic [RAW_W-1:0]   pos_z,
  input  logic               excluded,
  input  logic               last,
  input  logic               done,
  input  logic               found,
  input  logic [INDEX_W-1:0] best_index,
  input  logic [DIST_W-1:0]  best_distance_sq,
  input  logic               no_references,
  input  logic               overflow,
  output int                 mismatches,
  output int                 waiting,
  output int                 results_checked
);

  localparam longint DIST_CAP = longint'(DIST_MAX);

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] index;
    logic [DIST_W-1:0]  dist_sq;
    logic               no_refs;
    logic               ovf;
  } winner_t;

  longint  ref_x [MAX_REFERENCES];
  longint  ref_y [MAX_REFERENCES];
  longint  ref_z [MAX_REFERENCES];
  int      ref_count;
  int      cand_count;
  logic [INDEX_W-1:0] best_idx;
  longint  best_dist;
  logic    have_best;
  logic    dropped;

  winner_t winner_q[$];
  int      fail_n;
  int      checked_n;

  function automatic longint coord_value(input logic [RAW_W-1:0] raw);
    longint v;
    v = longint'(raw) & ((longint'(1) << COORD_BITS) - 1);
    if (v[COORD_BITS-1]) v = v - (longint'(1) << COORD_BITS);
    return v;
  endfunction

  function automatic longint sq_diff(input longint a, input longint b);
    longint dd;
    dd = a - b;
    return dd * dd;
  endfunction

  task automatic clear_selection();
    ref_count  = 0;
    cand_count = 0;
    best_idx   = '0;
    best_dist  = 0;
    have_best  = 1'b0;
    dropped    = 1'b0;
  endtask

  task automatic select_point(input logic f, input logic [RAW_W-1:0] rx,
                              input logic [RAW_W-1:0] ry, input logic [RAW_W-1:0] rz,
                              input logic excl, input logic lst);
    longint  px, py, pz, d, closest;
    winner_t w;
    px = coord_value(rx);
    py = coord_value(ry);
    pz = coord_value(rz);
    if (f == FUNC_REFERENCE) begin
      if (!excl) begin
        if (ref_count < MAX_REFERENCES) begin
          ref_x[ref_count] = px;
          ref_y[ref_count] = py;
          ref_z[ref_count] = pz;
          ref_count++;
        end else begin
          dropped = 1'b1;
        end
      end
    end else begin
      if (cand_count < MAX_CANDIDATES) begin
        closest = DIST_CAP;
        for (int i = 0; i < ref_count; i++) begin
          d = sq_diff(ref_x[i], px) + sq_diff(ref_y[i], py) + sq_diff(ref_z[i], pz);
          if (d > DIST_CAP) d = DIST_CAP;
          if (d < closest) closest = d;
        end
        if (ref_count == 0) closest = 0;
        if (!have_best || closest > best_dist) begin
          have_best = 1'b1;
          best_dist = closest;
          best_idx  = cand_count[INDEX_W-1:0];
        end
        cand_count++;
      end else begin
        dropped = 1'b1;
      end
      if (lst) begin
        w.found   = have_best;
        w.index   = have_best ? best_idx : '0;
        w.dist_sq = (have_best && ref_count != 0) ? best_dist[DIST_W-1:0] : '0;
        w.no_refs = (ref_count == 0);
        w.ovf     = dropped;
        winner_q.push_back(w);
        clear_selection();
      end
    end
  endtask

  task automatic check_winner();
    winner_t w;
    if (winner_q.size() == 0) begin
      if (fail_n < 10)
        $display("%0t: result with none pending: found=%0b idx=%0d dist=%0d nref=%0b ovf=%0b",
                 $realtime, found, best_index, best_distance_sq, no_references, overflow);
      fail_n++;
    end else begin
      w = winner_q.pop_front();
      checked_n++;
      if (found !== w.found || best_index !== w.index || best_distance_sq !== w.dist_sq ||
          no_references !== w.no_refs || overflow !== w.ovf) begin
        if (fail_n < 10)
          $display({"%0t: mismatch exp found=%0b idx=%0d dist=%0d nref=%0b ovf=%0b",
                    " | got found=%0b idx=%0d dist=%0d nref=%0b ovf=%0b"},
                   $realtime, w.found, w.index, w.dist_sq, w.no_refs, w.ovf,
                   found, best_index, best_distance_sq, no_references, overflow);
        fail_n++;
      end
    end
  endtask

  initial begin
    fail_n    = 0;
    checked_n = 0;
    clear_selection();
  end

  always @(posedge clk) begin
    if (rst) begin
      clear_selection();
      winner_q.delete();
    end else begin
      if (done) check_winner();
      if (start && !busy) select_point(func, pos_x, pos_y, pos_z, excluded, last);
    end
    mismatches      <= fail_n;
    waiting         <= winner_q.size();
    results_checked <= checked_n;
  end

endmodule

### dv/tb_max_min_distance_point_select.sv
module tb_max_min_distance_point_select;
  import mmdps_pkg::*;

  localparam int RANDOM_ITEMS   = 1850;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 100;

  localparam logic [RAW_W-1:0] COORD_MIN = {1'b1, {(RAW_W-1){1'b0}}};
  localparam logic [RAW_W-1:0] COORD_MAX = {1'b0, {(RAW_W-1){1'b1}}};
  localparam logic [RAW_W-1:0] COORD_ZERO = '0;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               func = FUNC_REFERENCE;
  logic [RAW_W-1:0]   pos_x = '0;
  logic [RAW_W-1:0]   pos_y = '0;
  logic [RAW_W-1:0]   pos_z = '0;
  logic               excluded = 1'b0;
  logic               last = 1'b0;
  logic               busy;
  logic               done;
  logic               found;
  logic [INDEX_W-1:0] best_index;
  logic [DIST_W-1:0]  best_distance_sq;
  logic               no_references;
  logic               overflow;

  int mismatches;
  int waiting;
  int results_checked;

  int idle_pct = 37;
  int points_sent = 0;
  int sessions = 0;
  int big_sessions = 0;
  int idle_cycles = 0;

  max_min_distance_point_select dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .excluded(excluded), .last(last),
    .done(done), .found(found), .best_index(best_index),
    .best_distance_sq(best_distance_sq), .no_references(no_references),
    .overflow(overflow)
  );

  mmdps_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .excluded(excluded), .last(last),
    .done(done), .found(found), .best_index(best_index),
    .best_distance_sq(best_distance_sq), .no_references(no_references),
    .overflow(overflow), .mismatches(mismatches), .waiting(waiting),
    .results_checked(results_checked)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_point(input logic f, input logic [RAW_W-1:0] x,
                            input logic [RAW_W-1:0] y, input logic [RAW_W-1:0] z,
                            input logic excl, input logic lst);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start    <= 1'b1;
    func     <= f;
    pos_x    <= x;
    pos_y    <= y;
    pos_z    <= z;
    excluded <= excl;
    last     <= lst;
    @(posedge clk);
    while (busy) @(posedge clk);
    points_sent++;
  endtask

  function automatic logic [RAW_W-1:0] rand_coord();
    logic [RAW_W-1:0] v;
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      case ($urandom_range(0, 3))
        0: v = COORD_MIN;
        1: v = COORD_MAX;
        2: v = COORD_ZERO;
        default: v = '1;
      endcase
    end else if (r < 50) begin
      v = RAW_W'(int'($urandom_range(0, 8)) - 4);
    end else begin
      v = RAW_W'($urandom);
    end
    return v;
  endfunction

  // One selection: references, then candidates (with a stray reference now and then) with last on the final one.
  task automatic run_session(output int counted);
    int  r, nref, ncand, stored;
    logic excl;
    counted = 0;
    r = $urandom_range(0, 99);
    if (r < 10)      nref = 0;
    else if (r < 80) nref = $urandom_range(1, 6);
    else if (r < 94) nref = $urandom_range(7, 30);
    else             nref = $urandom_range(62, 70);
    r = $urandom_range(0, 99);
    if (r < 80)      ncand = $urandom_range(1, 5);
    else if (r < 95) ncand = $urandom_range(6, 20);
    else             ncand = $urandom_range(62, 68);
    if (nref > MAX_REFERENCES || ncand > MAX_CANDIDATES) big_sessions++;
    stored = 0;
    while (stored < nref) begin
      excl = ($urandom_range(0, 99) < 15);
      send_point(FUNC_REFERENCE, rand_coord(), rand_coord(), rand_coord(), excl,
                 $urandom_range(0, 99) < 10);
      if (!excl) stored++;
    end
    counted += stored;
    for (int i = 0; i < ncand; i++) begin
      // drop a stray reference in among the candidates now and then
      if (i != ncand - 1 && $urandom_range(0, 99) < 10) begin
        send_point(FUNC_REFERENCE, rand_coord(), rand_coord(), rand_coord(), 1'b0, 1'b0);
        counted++;
      end
      send_point(FUNC_CANDIDATE, rand_coord(), rand_coord(), rand_coord(),
                 1'($urandom_range(0, 1)), i == ncand - 1);
      counted++;
    end
    sessions++;
  endtask

  initial begin
    int random_items, n;
    random_items = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // no references: first candidate wins
    send_point(FUNC_CANDIDATE, COORD_ZERO, COORD_ZERO, COORD_ZERO, 1'b1, 1'b0);
    send_point(FUNC_CANDIDATE, COORD_MAX, COORD_MIN, COORD_MAX, 1'b0, 1'b1);

    // corner references, excluded one, last on a reference, tie at zero
    send_point(FUNC_REFERENCE, COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, 1'b0);
    send_point(FUNC_REFERENCE, COORD_ZERO, COORD_ZERO, COORD_ZERO, 1'b1, 1'b0);
    send_point(FUNC_REFERENCE, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0, 1'b1);
    send_point(FUNC_CANDIDATE, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0, 1'b0);
    send_point(FUNC_CANDIDATE, COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, 1'b0);
    send_point(FUNC_CANDIDATE, COORD_ZERO, COORD_ZERO, COORD_ZERO, 1'b0, 1'b0);
    send_point(FUNC_CANDIDATE, COORD_MIN, COORD_MAX, COORD_ZERO, 1'b0, 1'b1);

    // equal nonzero distances: earlier candidate holds
    send_point(FUNC_REFERENCE, 20'd1, 20'd2, 20'd3, 1'b0, 1'b0);
    send_point(FUNC_REFERENCE, COORD_MAX, COORD_ZERO, COORD_MIN, 1'b1, 1'b0);
    send_point(FUNC_CANDIDATE, 20'd1, 20'd2, 20'd3, 1'b0, 1'b0);
    send_point(FUNC_CANDIDATE, 20'd4, 20'd6, 20'd3, 1'b0, 1'b0);
    send_point(FUNC_CANDIDATE, -20'sd2, -20'sd2, 20'd3, 1'b1, 1'b1);

    // only excluded references
    send_point(FUNC_REFERENCE, 20'd7, 20'd7, 20'd7, 1'b1, 1'b0);
    send_point(FUNC_REFERENCE, COORD_MIN, COORD_MAX, COORD_MIN, 1'b1, 1'b1);
    send_point(FUNC_CANDIDATE, -20'sd5, 20'd9, COORD_ZERO, 1'b0, 1'b1);

    while (random_items < RANDOM_ITEMS) begin
      if (random_items < RANDOM_ITEMS / 3)          idle_pct = 37;
      else if (random_items < 2 * RANDOM_ITEMS / 3) idle_pct = 53;
      else                                          idle_pct = 0;
      run_session(n);
      random_items += n;
    end

    @(negedge clk);
    start <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d point transactions over %0d selections (%0d past capacity).",
             points_sent, sessions + 4, big_sessions);
    $display("Checked %0d winner results, %0d mismatches.", results_checked, mismatches);
    if (mismatches == 0 && waiting == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
